### hdl/matrix3_inverse_adjugate_defines.svh
// assertion macros for the 3x3 adjugate inverse block
// no dependencies
`ifndef MATRIX3_INVERSE_ADJUGATE_DEFINES_SVH
`define MATRIX3_INVERSE_ADJUGATE_DEFINES_SVH

// implication checked every clock outside reset
`define M3I_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define M3I_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/m3inv_pkg.sv
// package for the 3x3 adjugate inverse block: types, widths, codes
// no dependencies
package m3inv_pkg;

  localparam int Dim = 3;
  localparam int ElemW = 16;
  localparam int AdjW = 33;
  localparam int InvW = 32;
  localparam int DetW = 51;
  localparam int ProdW = 2 * ElemW;
  localparam int DivW = AdjW + 24;   // magnitude of dividend width
  localparam int MagW = DetW;        // magnitude of divisor width

  localparam logic ActLoad = 1'b0;
  localparam logic ActCompute = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DET,
    ST_START,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [MagW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DivW-1:0] quotient;
  } div_stat_t;

endpackage

### hdl/m3inv_if.sv
// valid/ready channel interfaces for input and result transactions
// depends on m3inv_pkg
interface m3inv_in_if (input logic clk);
  import m3inv_pkg::*;
  logic valid;
  logic ready;
  logic action;
  logic [1:0] row_index;
  logic [1:0] col_index;
  logic signed [15:0] element_value;
  modport source (output valid, action, row_index, col_index, element_value, input ready);
  modport sink (input valid, action, row_index, col_index, element_value, output ready);
endinterface

interface m3inv_out_if (input logic clk);
  import m3inv_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] out_row;
  logic [1:0] out_col;
  logic signed [32:0] adjugate_entry;
  logic signed [31:0] inverse_entry;
  logic signed [50:0] determinant;
  logic singular;
  logic last_entry;
  modport source (output valid, out_row, out_col, adjugate_entry, inverse_entry,
                  determinant, singular, last_entry, input ready);
  modport sink (input valid, out_row, out_col, adjugate_entry, inverse_entry,
                determinant, singular, last_entry, output ready);
endinterface

### hdl/matrix3_inverse_adjugate.sv
// Channel  Dir  Payload
// in       sink action, row_index, col_index, element_value
// out      src  out_row, out_col, adjugate_entry, inverse_entry, determinant, ...
// a load writes one element while idle; a compute runs the cofactor multiplies and
// the determinant sum, then per entry a divider start, the divide and an output;
// a singular matrix does not wait for the divide and outputs zero inverse entries
// the divider gives one quotient bit a cycle; one multiplier is shared
// reset clears the sequencer and the divider's busy, done and count; the matrix store is undefined until written
// a stalled output holds the sequencer in the output state
module matrix3_inverse_adjugate (
  input logic clk,
  input logic rst,
  m3inv_in_if.sink   in_ch,
  m3inv_out_if.source out_ch
);
  import m3inv_pkg::*;
  `include "matrix3_inverse_adjugate_defines.svh"

  logic signed [ElemW-1:0] mat [Dim*Dim];
  logic signed [AdjW-1:0]  cof [Dim*Dim];
  logic signed [ProdW-1:0] prod_a;
  logic signed [DetW-1:0]  det;
  logic [4:0] step;
  logic [3:0] ent;
  logic [1:0] orow, ocol;
  state_t state, state_next;
  div_req_t req;
  div_stat_t dstat;
  logic signed [ElemW-1:0] ma;
  logic signed [AdjW-1:0] mb;
  logic signed [ElemW+AdjW-1:0] prod;
  logic [3:0] pp, pq;
  logic [1:0] r1, r2, c1, c2;
  logic signed [AdjW-1:0] cur_adj;
  logic [AdjW-1:0] adj_mag;
  logic [DetW-1:0] det_mag;
  logic neg;
  logic [InvW-1:0] inv_val;
  logic signed [InvW-1:0] inv_reg;

  function automatic logic [1:0] inc3(input logic [1:0] v, input logic [1:0] a);
    logic [2:0] s;
    s = {1'b0, v} + {1'b0, a};
    return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
  endfunction

  // cofactor k = p*3+q; step bit0 picks which product
  always_comb begin
    pp = (step[4:1] >= 4'd6) ? 4'd2 : ((step[4:1] >= 4'd3) ? 4'd1 : 4'd0);
    pq = step[4:1] - pp * 4'd3;
    r1 = inc3(pp[1:0], 2'd1);
    r2 = inc3(pp[1:0], 2'd2);
    c1 = inc3(pq[1:0], 2'd1);
    c2 = inc3(pq[1:0], 2'd2);
    if (!step[0]) begin
      ma = mat[4'(r1) * 4'd3 + 4'(c1)];
      mb = AdjW'(mat[4'(r2) * 4'd3 + 4'(c2)]);
    end else begin
      ma = mat[4'(r1) * 4'd3 + 4'(c2)];
      mb = AdjW'(mat[4'(r2) * 4'd3 + 4'(c1)]);
    end
    if (state == ST_DET) begin
      ma = mat[4'(step[1:0])];
      mb = cof[4'(step[1:0])];
    end
    prod = ma * mb;
  end

  // adjugate entry (r,c) = cofactor (c,r)
  assign cur_adj = cof[4'(ocol) * 4'd3 + 4'(orow)];
  assign adj_mag = cur_adj[AdjW-1] ? AdjW'(-cur_adj) : AdjW'(cur_adj);
  assign det_mag = det[DetW-1] ? DetW'(-det) : DetW'(det);
  assign neg = cur_adj[AdjW-1] ^ det[DetW-1];

  // saturate quotient
  always_comb begin
    if (neg) begin
      if (dstat.quotient >= DivW'(64'h80000000)) inv_val = 32'h80000000;
      else inv_val = InvW'(-dstat.quotient);
    end else begin
      if (dstat.quotient > DivW'(64'h7FFFFFFF)) inv_val = 32'h7FFFFFFF;
      else inv_val = dstat.quotient[InvW-1:0];
    end
  end

  always_comb begin
    req.start = 1'b0;
    req.dividend = {adj_mag, 24'd0};
    req.divisor = det_mag;
    state_next = state;
    case (state)
      ST_IDLE: if (in_ch.valid && in_ch.action == ActCompute) state_next = ST_MUL;
      ST_MUL:  if (step == 5'd17) state_next = ST_DET;
      ST_DET:  if (step == 5'd3) state_next = ST_START;
      ST_START: begin
        req.start = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (det == '0) state_next = ST_OUT;
        else if (dstat.done) state_next = ST_OUT;
      end
      ST_OUT: if (out_ch.ready) begin
        if (ent == 4'd8) state_next = ST_IDLE;
        else state_next = ST_START;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // load store and sequence the shared multiplier
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_ch.valid && in_ch.action == ActLoad &&
        in_ch.row_index != 2'd3 && in_ch.col_index != 2'd3)
      mat[4'(in_ch.row_index) * 4'd3 + 4'(in_ch.col_index)] <= in_ch.element_value;
    case (state)
      ST_IDLE: begin
        step <= '0;
        ent <= '0;
        orow <= '0;
        ocol <= '0;
        det <= '0;
      end
      ST_MUL: begin
        if (!step[0]) prod_a <= ProdW'(prod);
        else cof[step[4:1]] <= AdjW'(prod_a) - AdjW'(prod);
        step <= (step == 5'd17) ? 5'd0 : step + 5'd1;
      end
      ST_DET: begin
        if (step != 5'd3) begin
          det <= det + DetW'(prod);
        end
        step <= step + 5'd1;
      end
      ST_DIV: if (det == '0) inv_reg <= '0;
              else if (dstat.done) inv_reg <= inv_val;
      ST_OUT: if (out_ch.ready) begin
        ent <= ent + 4'd1;
        if (ocol == 2'd2) begin
          ocol <= '0;
          orow <= orow + 2'd1;
        end else ocol <= ocol + 2'd1;
      end
      default: ;
    endcase
  end

  m3inv_divider u_div (.clk(clk), .rst(rst), .req(req), .stat(dstat));

  assign in_ch.ready = (state == ST_IDLE);
  assign out_ch.valid = (state == ST_OUT);
  assign out_ch.out_row = orow;
  assign out_ch.out_col = ocol;
  assign out_ch.adjugate_entry = cur_adj;
  assign out_ch.inverse_entry = inv_reg;
  assign out_ch.determinant = det;
  assign out_ch.singular = (det == '0);
  assign out_ch.last_entry = (ent == 4'd8);

  `M3I_ASSERT_IMP(a_rdy_out, out_ch.valid, !in_ch.ready, "input ready during output")
  `M3I_ASSERT_IMP(a_last_pos, out_ch.last_entry && out_ch.valid,
                  orow == 2'd2 && ocol == 2'd2, "last marker misplaced")
  `M3I_ASSERT_NXT(a_div_start, req.start, dstat.busy, "divider did not start")
endmodule

### hdl/m3inv_divider.sv
// restoring divider, one quotient bit per cycle, unsigned magnitudes
// depends on m3inv_pkg
module m3inv_divider (
  input  logic                  clk,
  input  logic                  rst,
  input  m3inv_pkg::div_req_t   req,
  output m3inv_pkg::div_stat_t  stat
);
  import m3inv_pkg::*;

  logic [DivW-1:0] quo;
  logic [MagW:0]   rem;
  logic [MagW-1:0] dvs;
  logic [5:0]      cnt;
  logic            busy;
  logic            done;
  logic [MagW:0]   trial;
  logic [MagW+1:0] shifted;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    shifted = {rem, quo[DivW-1]};
    trial = shifted[MagW:0] - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 6'(DivW);
        quo <= req.dividend;
        rem <= '0;
        dvs <= req.divisor;
      end else if (busy) begin
        if (shifted[MagW:0] >= {1'b0, dvs}) begin
          rem <= trial;
          quo <= {quo[DivW-2:0], 1'b1};
        end else begin
          rem <= shifted[MagW:0];
          quo <= {quo[DivW-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.quotient = quo;
endmodule
